// ===== design/ncofs_pkg.sv =====
`timescale 1ns / 1ps
// ncofs_pkg: shared types, constants and the quarter-wave sine table builder
// for the NCO frequency shifter. No dependencies.
package ncofs_pkg;

    localparam int              LUT_W      = 15;
    localparam int              ROUND_BITS = 15;
    localparam logic [63:0]     PI_Q30     = 64'd3373259426;
    localparam logic [63:0]     AMPL_U     = 64'd32767;
    localparam logic signed [16:0] LUT_AMPL = 17'sd32767;

    // per-word lookup control, passed from front to back through the queue
    typedef struct packed {
        logic bypass;
        logic sin_one;
        logic sin_neg;
        logic cos_one;
        logic cos_neg;
    } t_lut_ctrl;

    // one Taylor step: term / ((2n)(2n+1))
    function automatic logic [63:0] taylor_div(input logic [63:0] t, input int n);
        logic [63:0] r;
        case (n)
            1:       r = t / 64'd6;
            2:       r = t / 64'd20;
            3:       r = t / 64'd42;
            4:       r = t / 64'd72;
            5:       r = t / 64'd110;
            6:       r = t / 64'd156;
            7:       r = t / 64'd210;
            8:       r = t / 64'd272;
            9:       r = t / 64'd342;
            10:      r = t / 64'd420;
            default: r = t;
        endcase
        return r;
    endfunction

    // entry k of a quarter-wave table with 2^qbits entries, Q30 series
    function automatic logic [LUT_W-1:0] sin_entry(input int unsigned k,
                                                   input int unsigned qbits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (PI_Q30 * 64'(k)) >> (qbits + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= 10; n++) begin
            term = taylor_div((term * x2) >> 30, n);
            if ((n % 2) == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        v = ((unsigned'(sum) * AMPL_U) + (64'd1 << 29)) >> 30;
        if (v > AMPL_U) begin
            v = AMPL_U;
        end
        return v[LUT_W-1:0];
    endfunction

endpackage

// ===== design/ncofs_front.sv =====
`timescale 1ns / 1ps
// ncofs_front: phase step register, phase accumulator and table address
// classification. Depends on ncofs_pkg.
module ncofs_front
    import ncofs_pkg::*;
#(
    parameter int SAMPLE_BITS     = 16,
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [31:0]                  i_cfg_data,
    input  logic                         i_valid,
    input  logic                         i_first,
    input  logic [SAMPLE_BITS-1:0]       i_i,
    input  logic [SAMPLE_BITS-1:0]       i_q,
    input  logic                         i_full,
    output logic                         o_push,
    output logic [SAMPLE_BITS-1:0]       o_i,
    output logic [SAMPLE_BITS-1:0]       o_q,
    output logic [TABLE_ADDR_BITS-3:0]   o_sin_idx,
    output logic [TABLE_ADDR_BITS-3:0]   o_cos_idx,
    output t_lut_ctrl                    o_ctrl
);

    localparam int QB = TABLE_ADDR_BITS - 2;

    logic [31:0]                r_step;
    logic [PHASE_BITS-1:0]      r_acc;
    logic [PHASE_BITS-1:0]      n_acc;
    logic [63:0]                w_step64;
    logic [PHASE_BITS-1:0]      w_phase;
    logic [TABLE_ADDR_BITS-1:0] w_sin_addr;
    logic [TABLE_ADDR_BITS-1:0] w_cos_addr;
    logic [QB-1:0]              w_sin_j;
    logic [QB-1:0]              w_cos_j;

    assign w_step64   = {{32{r_step[31]}}, r_step};
    assign w_phase    = i_first ? '0 : r_acc;
    assign n_acc      = w_phase + w_step64[PHASE_BITS-1:0];
    assign w_sin_addr = w_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    assign w_cos_addr = w_sin_addr + TABLE_ADDR_BITS'(1 << QB);
    assign w_sin_j    = w_sin_addr[QB-1:0];
    assign w_cos_j    = w_cos_addr[QB-1:0];

    assign o_push = i_valid && !i_full;
    assign o_i    = i_i;
    assign o_q    = i_q;

    // odd quadrants read the mirrored entry; a zero offset there is the peak
    assign o_sin_idx = w_sin_addr[QB] ? (QB'(0) - w_sin_j) : w_sin_j;
    assign o_cos_idx = w_cos_addr[QB] ? (QB'(0) - w_cos_j) : w_cos_j;

    always_comb begin
        o_ctrl.bypass  = (r_step == '0);
        o_ctrl.sin_one = w_sin_addr[QB] && (w_sin_j == '0);
        o_ctrl.sin_neg = w_sin_addr[QB+1];
        o_ctrl.cos_one = w_cos_addr[QB] && (w_cos_j == '0);
        o_ctrl.cos_neg = w_cos_addr[QB+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_acc  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_cfg_data;
            end
            if (o_push) begin
                r_acc <= n_acc;
            end
        end
    end

endmodule

// ===== design/ncofs_queue.sv =====
`timescale 1ns / 1ps
// ncofs_queue: short word queue between front and back.
// Depends on nothing but its parameters.
module ncofs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");
`endif

endmodule

// ===== design/ncofs_back.sv =====
`timescale 1ns / 1ps
// ncofs_back: sine ROM read, phasor sign, complex multiply, rounding and
// saturation (or a zero-step bypass), output register. Depends on ncofs_pkg.
module ncofs_back
    import ncofs_pkg::*;
#(
    parameter int SAMPLE_BITS     = 16,
    parameter int TABLE_ADDR_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [SAMPLE_BITS-1:0]     i_i,
    input  logic signed [SAMPLE_BITS-1:0]     i_q,
    input  logic [TABLE_ADDR_BITS-3:0]        i_sin_idx,
    input  logic [TABLE_ADDR_BITS-3:0]        i_cos_idx,
    input  t_lut_ctrl                         i_ctrl,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_i,
    output logic signed [SAMPLE_BITS-1:0]     o_q
);

    localparam int QB     = TABLE_ADDR_BITS - 2;
    localparam int QDEPTH = 1 << QB;
    localparam int SB     = SAMPLE_BITS;
    localparam int PW     = SB + 17;
    localparam int SW     = PW + 1;
    localparam int RW     = SW - ROUND_BITS;
    localparam logic signed [SW-1:0] RND_HALF = SW'(32'sd16384);
    localparam logic signed [RW-1:0] SAT_MAX  = {{(RW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_MIN  = {{(RW-SB+1){1'b1}}, {(SB-1){1'b0}}};

    logic [LUT_W-1:0] w_rom [QDEPTH];

    for (genvar k = 0; k < QDEPTH; k++) begin : g_rom
        assign w_rom[k] = sin_entry(k, QB);
    end

    logic                 w_adv;
    logic                 r_v1, r_v2, r_v3, r_out_valid;
    logic [LUT_W-1:0]     r_sin_raw, r_cos_raw;
    t_lut_ctrl            r_ctrl1;
    logic signed [SB-1:0] r_i1, r_q1, r_i2, r_q2, r_i3, r_q3;
    logic signed [16:0]   w_s, w_c, r_s2, r_c2;
    logic                 r_byp2, r_byp3;
    logic signed [PW-1:0] r_ic, r_qs, r_is, r_qc;
    logic signed [SW-1:0] w_sum_i, w_sum_q;
    logic signed [RW-1:0] w_rnd_i, w_rnd_q;
    logic signed [SB-1:0] w_sat_i, w_sat_q;
    logic signed [SB-1:0] r_out_i, r_out_q;

    assign w_adv   = !r_out_valid || i_ready;
    assign o_pop   = w_adv && i_valid;
    assign o_valid = r_out_valid;
    assign o_i     = r_out_i;
    assign o_q     = r_out_q;

    always_comb begin
        w_s = r_ctrl1.sin_one ? LUT_AMPL : signed'({2'b00, r_sin_raw});
        w_c = r_ctrl1.cos_one ? LUT_AMPL : signed'({2'b00, r_cos_raw});
        if (r_ctrl1.sin_neg) begin
            w_s = -w_s;
        end
        if (r_ctrl1.cos_neg) begin
            w_c = -w_c;
        end
    end

    assign w_sum_i = SW'(r_ic) - SW'(r_qs);
    assign w_sum_q = SW'(r_is) + SW'(r_qc);
    assign w_rnd_i = RW'((w_sum_i + RND_HALF) >>> ROUND_BITS);
    assign w_rnd_q = RW'((w_sum_q + RND_HALF) >>> ROUND_BITS);

    always_comb begin
        if (w_rnd_i > SAT_MAX) begin
            w_sat_i = SAT_MAX[SB-1:0];
        end else if (w_rnd_i < SAT_MIN) begin
            w_sat_i = SAT_MIN[SB-1:0];
        end else begin
            w_sat_i = w_rnd_i[SB-1:0];
        end
        if (w_rnd_q > SAT_MAX) begin
            w_sat_q = SAT_MAX[SB-1:0];
        end else if (w_rnd_q < SAT_MIN) begin
            w_sat_q = SAT_MIN[SB-1:0];
        end else begin
            w_sat_q = w_rnd_q[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sin_raw <= w_rom[i_sin_idx];
            r_cos_raw <= w_rom[i_cos_idx];
            r_ctrl1   <= i_ctrl;
            r_i1      <= i_i;
            r_q1      <= i_q;
            r_s2      <= w_s;
            r_c2      <= w_c;
            r_byp2    <= r_ctrl1.bypass;
            r_i2      <= r_i1;
            r_q2      <= r_q1;
            r_ic      <= r_i2 * r_c2;
            r_qs      <= r_q2 * r_s2;
            r_is      <= r_i2 * r_s2;
            r_qc      <= r_q2 * r_c2;
            r_byp3    <= r_byp2;
            r_i3      <= r_i2;
            r_q3      <= r_q2;
            r_out_i   <= r_byp3 ? r_i3 : w_sat_i;
            r_out_q   <= r_byp3 ? r_q3 : w_sat_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
        end
    end

`ifndef SYNTH
    a_stage_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_v3) |=> r_out_valid)
        else $error("pipeline word lost before output");
    a_bypass_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_v3 && r_byp3) |=> (r_out_i == $past(r_i3) && r_out_q == $past(r_q3)))
        else $error("zero-step word altered");
`endif

endmodule

// ===== design/nco_complex_frequency_shifter.sv =====
`timescale 1ns / 1ps
// NCO complex frequency shifter, top level. Depends on ncofs_pkg and the
// ncofs_front, ncofs_queue and ncofs_back modules.
// Path: an accepted word passes the queue write, then ROM read, phasor sign, multiply
//   and round/saturate into the output register; it is held while m_axis_tready is low.
// Throughput: one word per clock while m_axis_tready stays high; held low, the queue fills and s_axis_tready drops.
// Reset (sync, active low) clears phase, phase step, queue and pipeline valids.
module nco_complex_frequency_shifter
    import ncofs_pkg::*;
#(
    parameter int SAMPLE_BITS     = 16,
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [31:0]                            i_cfg_data,     // phase_step
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,   // in_i, in_q
    input  logic [0:0]                             s_axis_tuser,   // first
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata    // out_i, out_q
);

    localparam int DW    = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int QB    = TABLE_ADDR_BITS - 2;
    localparam int CW    = $bits(t_lut_ctrl);
    localparam int QW    = 2*SAMPLE_BITS + 2*QB + CW;
    localparam int QDEPTH = 4;

    logic                   w_push, w_pop, w_q_valid, w_full;
    logic [SAMPLE_BITS-1:0] w_f_i, w_f_q;
    logic [QB-1:0]          w_f_sin, w_f_cos;
    t_lut_ctrl              w_f_ctrl;
    logic [QW-1:0]          w_q_in, w_q_out;
    logic [SAMPLE_BITS-1:0] w_b_i, w_b_q;
    logic [QB-1:0]          w_b_sin, w_b_cos;
    t_lut_ctrl              w_b_ctrl;
    logic [SAMPLE_BITS-1:0] w_out_i, w_out_q;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !w_full;

    ncofs_front #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_first     (s_axis_tuser[0]),
        .i_i         (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_q         (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_i         (w_f_i),
        .o_q         (w_f_q),
        .o_sin_idx   (w_f_sin),
        .o_cos_idx   (w_f_cos),
        .o_ctrl      (w_f_ctrl)
    );

    assign w_q_in = {w_f_ctrl, w_f_cos, w_f_sin, w_f_q, w_f_i};
    assign {w_b_ctrl, w_b_cos, w_b_sin, w_b_q, w_b_i} = w_q_out;

    ncofs_queue #(
        .WIDTH (QW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_full),
        .o_data  (w_q_out)
    );

    ncofs_back #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_q_valid),
        .i_i       (signed'(w_b_i)),
        .i_q       (signed'(w_b_q)),
        .i_sin_idx (w_b_sin),
        .i_cos_idx (w_b_cos),
        .i_ctrl    (w_b_ctrl),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_i       (w_out_i),
        .o_q       (w_out_q)
    );

    assign m_axis_tdata = DW'({w_out_q, w_out_i});

endmodule
